### design/sfr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the schlick fresnel reflectance pipeline
// no dependencies; imported by the top, front and back modules of the block
package sfr_pkg;

  localparam int unsigned REFL_FRAC_BITS = 16;
  localparam int unsigned QB             = 28;
  localparam int unsigned QW             = QB + 1;
  localparam int unsigned IOR_W          = 14;
  localparam int unsigned VEC_W          = 16;

  localparam logic [QB:0] ONE_Q = {1'b1, {QB{1'b0}}};
  localparam logic [QB:0] RND_HALF = QW'(1) << (QB - REFL_FRAC_BITS - 1);
  localparam logic [REFL_FRAC_BITS:0] OUT_ONE = {1'b1, {REFL_FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic signed [VEC_W-1:0] eye_x;
    logic signed [VEC_W-1:0] eye_y;
    logic signed [VEC_W-1:0] eye_z;
    logic signed [VEC_W-1:0] normal_x;
    logic signed [VEC_W-1:0] normal_y;
    logic signed [VEC_W-1:0] normal_z;
    logic [IOR_W-1:0]        ior_from;
    logic [IOR_W-1:0]        ior_to;
  } in_item_t;

  typedef struct packed {
    logic [REFL_FRAC_BITS:0] reflectance;
    logic                    total_internal;
  } out_item_t;

  typedef struct packed {
    logic gt;   // leaving the denser medium
    logic tir;
  } flags_t;

endpackage

### design/schlick_fresnel_reflectance.sv
`timescale 1ns / 1ps
// schlick fresnel reflectance with total internal reflection, full-rate pipeline
// depth: 5 front stages, 29-stage dividers, 29-stage square root, 7 back stages
// throughput one item per cycle unless stalled; bit-per-stage divider and root set depth
// a held result at the output freezes the whole pipeline; bubbles still advance otherwise
// rst_ni clears all valid bits asynchronously; payload registers are not reset
module schlick_fresnel_reflectance
  import sfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned SQW = 2 * IOR_W;

  logic            en;
  logic            fr_valid;
  logic [QB:0]     fr_c;
  logic [2*QB:0]   fr_snum;
  logic [SQW-1:0]  fr_sden;
  logic [2*QB-1:0] fr_rnum;
  logic [SQW+1:0]  fr_rden;
  flags_t          fr_flags;

  logic            ds_valid, dr_valid;
  logic [QB:0]     s2t, r0, ds_c;
  flags_t          dr_flags;

  logic            sq_valid;
  logic [QB:0]     root, sq_c, sq_r0;
  flags_t          sq_flags;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  sfr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (fr_valid),
    .c_o     (fr_c),
    .snum_o  (fr_snum),
    .sden_o  (fr_sden),
    .rnum_o  (fr_rnum),
    .rden_o  (fr_rden),
    .flags_o (fr_flags)
  );

  // sin^2 of the transmitted angle
  sfr_div #(.NW(2*QB+1), .DW(SQW), .QWD(QW), .SW(QW)) u_div_s2t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   (fr_snum),
    .den_i   (fr_sden),
    .side_i  (fr_c),
    .valid_o (ds_valid),
    .quo_o   (s2t),
    .side_o  (ds_c)
  );

  // r0 = ((n1-n2)/(n1+n2))^2
  sfr_div #(.NW(2*QB), .DW(SQW+2), .QWD(QW), .SW($bits(flags_t))) u_div_r0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   (fr_rnum),
    .den_i   (fr_rden),
    .side_i  (fr_flags),
    .valid_o (dr_valid),
    .quo_o   (r0),
    .side_o  (dr_flags)
  );

  sfr_sqrt #(.RTW(QW), .SW(2*QW + $bits(flags_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ds_valid),
    .rad_i   ({1'b0, ONE_Q - s2t, {QB{1'b0}}}),
    .side_i  ({ds_c, r0, dr_flags}),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  ({sq_c, sq_r0, sq_flags})
  );

  sfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (root),
    .c_i     (sq_c),
    .r0_i    (sq_r0),
    .flags_i (sq_flags),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_valid == dr_valid)
    else $error("divider lanes out of step");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid && sq_flags.gt && !sq_flags.tir |-> root <= ONE_Q)
    else $error("refracted cosine above one");

  a_tir_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.total_internal |-> out_item_o.reflectance == OUT_ONE)
    else $error("tir item without full reflectance");

  a_refl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.reflectance <= OUT_ONE)
    else $error("reflectance above one");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

### design/sfr_front.sv
`timescale 1ns / 1ps
// front end: dot product, clamp, index squares, sin^2 numerator and tir test
// five register stages; uses sfr_pkg
module sfr_front
  import sfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  in_item_t         item_i,
  output logic             valid_o,
  output logic [QB:0]      c_o,
  output logic [2*QB:0]    snum_o,
  output logic [2*IOR_W-1:0] sden_o,
  output logic [2*QB-1:0]  rnum_o,
  output logic [2*IOR_W+1:0] rden_o,
  output flags_t           flags_o
);

  localparam int unsigned SQW = 2 * IOR_W;

  logic [4:0] v_q;

  // stage 1
  logic signed [31:0] p_d [3];
  logic signed [31:0] p_q [3];
  logic [IOR_W-1:0] n1_q, n2_q, dif_q;
  logic [IOR_W:0]   sum_q;
  logic             gt1_q;

  // stage 2
  logic signed [33:0] dot;
  logic [QB:0]      c2_d, c2_q;
  logic [SQW-1:0]   n1sq2_q, n2sq2_q, d2_2_q;
  logic [SQW+1:0]   ssq2_q;
  logic             gt2_q;

  // stage 3
  logic [2*QB+1:0]  cc;
  logic [QB:0]      s2i3_q, c3_q;
  logic [SQW-1:0]   n1sq3_q, n2sq3_q, d2_3_q;
  logic [SQW+1:0]   ssq3_q;
  logic             gt3_q;

  // stage 4
  logic [2*QB:0]    num4_q;
  logic             s2inz4_q;
  logic [QB:0]      c4_q;
  logic [SQW-1:0]   n2sq4_q, d2_4_q;
  logic [SQW+1:0]   ssq4_q;
  logic             gt4_q;

  // stage 5
  logic [2*QB:0]    thr;
  logic             tir5;
  logic [QB:0]      c5_q;
  logic [2*QB:0]    snum5_q;
  logic [SQW-1:0]   sden5_q;
  logic [2*QB-1:0]  rnum5_q;
  logic [SQW+1:0]   rden5_q;
  flags_t           flags5_q;

  always_comb begin
    p_d[0] = 32'(item_i.eye_x) * 32'(item_i.normal_x);
    p_d[1] = 32'(item_i.eye_y) * 32'(item_i.normal_y);
    p_d[2] = 32'(item_i.eye_z) * 32'(item_i.normal_z);
  end

  always_comb begin
    dot = 34'(p_q[0]) + 34'(p_q[1]) + 34'(p_q[2]);
    if (dot[33]) begin
      c2_d = '0;
    end else if (dot > $signed({5'b0, ONE_Q})) begin
      c2_d = ONE_Q;
    end else begin
      c2_d = dot[QB:0];
    end
  end

  assign cc  = 58'(c2_q) * 58'(c2_q);
  assign thr = {1'b0, n2sq4_q, {QB{1'b0}}} + (2*QB+1)'(n2sq4_q);
  // a zero entered index means an unbounded ratio
  assign tir5 = gt4_q && ((n2sq4_q == '0) ? s2inz4_q : (num4_q >= thr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= p_d[k];
      end
      n1_q  <= item_i.ior_from;
      n2_q  <= item_i.ior_to;
      gt1_q <= item_i.ior_from > item_i.ior_to;
      dif_q <= (item_i.ior_from > item_i.ior_to) ? item_i.ior_from - item_i.ior_to
                                                  : item_i.ior_to - item_i.ior_from;
      sum_q <= (IOR_W+1)'(item_i.ior_from) + (IOR_W+1)'(item_i.ior_to);

      c2_q    <= c2_d;
      n1sq2_q <= SQW'(n1_q) * SQW'(n1_q);
      n2sq2_q <= SQW'(n2_q) * SQW'(n2_q);
      d2_2_q  <= SQW'(dif_q) * SQW'(dif_q);
      ssq2_q  <= (SQW+2)'(sum_q) * (SQW+2)'(sum_q);
      gt2_q   <= gt1_q;

      s2i3_q  <= ONE_Q - cc[QB +: QW];
      c3_q    <= c2_q;
      n1sq3_q <= n1sq2_q;
      n2sq3_q <= n2sq2_q;
      d2_3_q  <= d2_2_q;
      ssq3_q  <= ssq2_q;
      gt3_q   <= gt2_q;

      num4_q   <= (2*QB+1)'(n1sq3_q) * (2*QB+1)'(s2i3_q);
      s2inz4_q <= s2i3_q != '0;
      c4_q     <= c3_q;
      n2sq4_q  <= n2sq3_q;
      d2_4_q   <= d2_3_q;
      ssq4_q   <= ssq3_q;
      gt4_q    <= gt3_q;

      // zero divisors: force a zero quotient, the model's value there
      c5_q         <= c4_q;
      snum5_q      <= (n2sq4_q == '0) ? '0 : num4_q;
      sden5_q      <= (n2sq4_q == '0) ? SQW'(1) : n2sq4_q;
      rnum5_q      <= {d2_4_q, {QB{1'b0}}};
      rden5_q      <= (ssq4_q == '0) ? (SQW+2)'(1) : ssq4_q;
      flags5_q.gt  <= gt4_q;
      flags5_q.tir <= tir5;
    end
  end

  assign valid_o = v_q[4];
  assign c_o     = c5_q;
  assign snum_o  = snum5_q;
  assign sden_o  = sden5_q;
  assign rnum_o  = rnum5_q;
  assign rden_o  = rden5_q;
  assign flags_o = flags5_q;

endmodule

### design/sfr_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// needs num < den * 2^QWD; no package dependency
module sfr_div #(
  parameter int unsigned NW  = 57,
  parameter int unsigned DW  = 28,
  parameter int unsigned QWD = 29,
  parameter int unsigned SW  = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [QWD-1:0] quo_o,
  output logic [SW-1:0]  side_o
);

  localparam int unsigned RW = DW + 1;

  logic [QWD-1:0] v_q;
  logic [RW-1:0]  rem_q [QWD];
  logic [QWD-1:0] low_q [QWD];
  logic [QWD-1:0] quo_q [QWD];
  logic [DW-1:0]  den_q [QWD];
  logic [SW-1:0]  side_q [QWD];

  logic [RW-1:0]  rem_in [QWD];
  logic [QWD-1:0] low_in [QWD];
  logic [QWD-1:0] quo_in [QWD];
  logic [DW-1:0]  den_in [QWD];
  logic [SW-1:0]  side_in [QWD];

  logic [RW-1:0]  sh [QWD];
  logic           ge [QWD];
  logic [RW-1:0]  rem_d [QWD];
  logic [QWD-1:0] low_d [QWD];
  logic [QWD-1:0] quo_d [QWD];

  always_comb begin
    rem_in[0]  = RW'(num_i[NW-1:QWD]);
    low_in[0]  = num_i[QWD-1:0];
    quo_in[0]  = '0;
    den_in[0]  = den_i;
    side_in[0] = side_i;
    for (int k = 1; k < QWD; k++) begin
      rem_in[k]  = rem_q[k-1];
      low_in[k]  = low_q[k-1];
      quo_in[k]  = quo_q[k-1];
      den_in[k]  = den_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < QWD; k++) begin
      // partial remainder stays below den, so its top bit is free
      sh[k]    = {rem_in[k][RW-2:0], low_in[k][QWD-1]};
      ge[k]    = sh[k] >= {1'b0, den_in[k]};
      rem_d[k] = ge[k] ? sh[k] - {1'b0, den_in[k]} : sh[k];
      low_d[k] = {low_in[k][QWD-2:0], 1'b0};
      quo_d[k] = {quo_in[k][QWD-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QWD-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QWD; k++) begin
        rem_q[k]  <= rem_d[k];
        low_q[k]  <= low_d[k];
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = v_q[QWD-1];
  assign quo_o   = quo_q[QWD-1];
  assign side_o  = side_q[QWD-1];

endmodule

### design/sfr_sqrt.sv
`timescale 1ns / 1ps
// pipelined digit-by-digit integer square root, one root bit per stage
// no package dependency
module sfr_sqrt #(
  parameter int unsigned RTW = 29,
  parameter int unsigned SW  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*RTW-1:0] rad_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [RTW-1:0]   root_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned REMW = RTW + 2;

  logic [RTW-1:0]   v_q;
  logic [REMW-1:0]  rem_q [RTW];
  logic [2*RTW-1:0] rad_q [RTW];
  logic [RTW-1:0]   root_q [RTW];
  logic [SW-1:0]    side_q [RTW];

  logic [REMW-1:0]  rem_in [RTW];
  logic [2*RTW-1:0] rad_in [RTW];
  logic [RTW-1:0]   root_in [RTW];
  logic [SW-1:0]    side_in [RTW];

  logic [REMW+1:0]  sh [RTW];
  logic [REMW+1:0]  trial [RTW];
  logic             ge [RTW];
  logic [REMW-1:0]  rem_d [RTW];
  logic [2*RTW-1:0] rad_d [RTW];
  logic [RTW-1:0]   root_d [RTW];

  always_comb begin
    rem_in[0]  = '0;
    rad_in[0]  = rad_i;
    root_in[0] = '0;
    side_in[0] = side_i;
    for (int k = 1; k < RTW; k++) begin
      rem_in[k]  = rem_q[k-1];
      rad_in[k]  = rad_q[k-1];
      root_in[k] = root_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < RTW; k++) begin
      sh[k]     = {rem_in[k], rad_in[k][2*RTW-1 -: 2]};
      trial[k]  = (REMW+2)'({root_in[k], 2'b01});
      ge[k]     = sh[k] >= trial[k];
      rem_d[k]  = REMW'(ge[k] ? sh[k] - trial[k] : sh[k]);
      rad_d[k]  = {rad_in[k][2*RTW-3:0], 2'b00};
      root_d[k] = {root_in[k][RTW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RTW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RTW; k++) begin
        rem_q[k]  <= rem_d[k];
        rad_q[k]  <= rad_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = v_q[RTW-1];
  assign root_o  = root_q[RTW-1];
  assign side_o  = side_q[RTW-1];

endmodule

### design/sfr_back.sv
`timescale 1ns / 1ps
// back end: (1-cos)^5 over four multiply stages, schlick blend, rounding
// holds the output register; uses sfr_pkg
module sfr_back
  import sfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  logic [QB:0] root_i,
  input  logic [QB:0] c_i,
  input  logic [QB:0] r0_i,
  input  flags_t    flags_i,
  output logic      valid_o,
  output out_item_t item_o
);

  localparam int unsigned NPOW = 4;

  logic          v0_q;
  logic [QB:0]   x0_q, r00_q;
  logic          tir0_q;

  logic [NPOW-1:0] vp_q;
  logic [QB:0]   p_q [NPOW];
  logic [QB:0]   xs_q [NPOW];
  logic [QB:0]   r0s_q [NPOW];
  logic          tirs_q [NPOW];

  logic [QB:0]   p_in [NPOW];
  logic [QB:0]   x_in [NPOW];
  logic [QB:0]   r0_in [NPOW];
  logic          tir_in [NPOW];
  logic          v_in [NPOW];
  logic [2*QB+1:0] prod [NPOW];

  logic [2*QB+1:0] bprod;
  logic          v5_q, tir5_q;
  logic [QB+1:0] r5_q;

  logic [QB:0]   rc;
  logic [QB+1:0] rr;
  logic          v6_q;
  out_item_t     item6_q;

  always_comb begin
    p_in[0]   = x0_q;
    x_in[0]   = x0_q;
    r0_in[0]  = r00_q;
    tir_in[0] = tir0_q;
    v_in[0]   = v0_q;
    for (int k = 1; k < NPOW; k++) begin
      p_in[k]   = p_q[k-1];
      x_in[k]   = xs_q[k-1];
      r0_in[k]  = r0s_q[k-1];
      tir_in[k] = tirs_q[k-1];
      v_in[k]   = vp_q[k-1];
    end
    for (int k = 0; k < NPOW; k++) begin
      prod[k] = (2*QB+2)'(p_in[k]) * (2*QB+2)'(x_in[k]);
    end
  end

  assign bprod = (2*QB+2)'(ONE_Q - r0s_q[NPOW-1]) * (2*QB+2)'(p_q[NPOW-1]);

  always_comb begin
    rc = (r5_q > (QB+2)'(ONE_Q)) ? ONE_Q : r5_q[QB:0];
    rr = (QB+2)'(rc) + (QB+2)'(RND_HALF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vp_q <= '0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      for (int k = 0; k < NPOW; k++) begin
        vp_q[k] <= v_in[k];
      end
      v5_q <= vp_q[NPOW-1];
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // refracted cosine only when leaving the denser medium
      x0_q   <= ONE_Q - (flags_i.gt ? root_i : c_i);
      r00_q  <= r0_i;
      tir0_q <= flags_i.tir;
      for (int k = 0; k < NPOW; k++) begin
        p_q[k]    <= prod[k][QB +: QW];
        xs_q[k]   <= x_in[k];
        r0s_q[k]  <= r0_in[k];
        tirs_q[k] <= tir_in[k];
      end
      r5_q   <= (QB+2)'(r0s_q[NPOW-1]) + bprod[QB +: QB+2];
      tir5_q <= tirs_q[NPOW-1];
      item6_q.reflectance    <= tir5_q ? OUT_ONE
                                       : rr[QB -: REFL_FRAC_BITS+1];
      item6_q.total_internal <= tir5_q;
    end
  end

  assign valid_o = v6_q;
  assign item_o  = item6_q;

endmodule
